### sv/pn3t_pkg.sv
// Shared types, constants and the gradient function of the 3-D Perlin noise block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pn3t_pkg;

	// Sizes of the table, the fraction and the voxel range.
	localparam int TABLE_DEPTH = 256;
	localparam int FRAC_BITS   = 16;
	localparam int VOXEL_LIMIT = 1024;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Derived widths: gradient values, fade weights, lerp products, fade poly.
	localparam int GW = FRAC_BITS + 2;
	localparam int TW = FRAC_BITS + 1;
	localparam int PW = 2 * FRAC_BITS + 5;
	localparam int QW = FRAC_BITS + 4;

	// Widths fixed by the interface fields.
	localparam int VOX_W   = 10;
	localparam int ORG_W   = 24;
	localparam int FREQ_W  = 20;
	localparam int THR_W   = 18;
	localparam int NOISE_W = 18;
	localparam int POS_W   = ORG_W + 1;
	localparam int MUL_W   = POS_W + FREQ_W + 1;
	localparam int CELL_LSB = 24;

	// Item kinds carried on the input tuser.
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_FREQUENCY = 3'd3,
		REG_THRESHOLD = 3'd4
	} reg_idx_t;

	typedef logic [7:0]            perm_t;
	typedef logic [TABLE_AW-1:0]   tidx_t;
	typedef logic [FRAC_BITS-1:0]  frac_t;
	typedef logic [TW-1:0]         fade_t;
	typedef logic signed [GW-1:0]  gval_t;
	typedef logic signed [PW-1:0]  prod_t;
	typedef logic [QW-1:0]         poly_t;

	// Coordinate settings used by the front.
	typedef struct packed {
		logic signed [ORG_W-1:0] origin_x;
		logic signed [ORG_W-1:0] origin_y;
		logic signed [ORG_W-1:0] origin_z;
		logic [FREQ_W-1:0]       frequency;
	} cfg_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic  mode;
		tidx_t tindex;
		perm_t tvalue;
		tidx_t cx;
		tidx_t cy;
		tidx_t cz;
		frac_t fx;
		frac_t fy;
		frac_t fz;
	} item_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic           head_valid;
		logic [QCW-1:0] count;
	} qstat_t;

	// Improved noise gradient: picks +-u +- v from the low four hash bits.
	function automatic gval_t grad(input perm_t hash, input gval_t x, input gval_t y,
		input gval_t z);
		logic [3:0] h;
		gval_t      uu;
		gval_t      vv;
		h  = hash[3:0];
		uu = h[3] ? y : x;
		if (h < 4'd4) begin
			vv = y;
		end else if (h == 4'd12 || h == 4'd14) begin
			vv = x;
		end else begin
			vv = z;
		end
		return (h[0] ? -uu : uu) + (h[1] ? -vv : vv);
	endfunction

endpackage

`default_nettype wire

### sv/perlin_noise_3d_threshold_top.sv
// Top level of the 3-D Perlin noise block with solidity threshold.
// Depends on pn3t_pkg, pn3t_front, pn3t_queue and pn3t_back.
//
// Usage:
//   The s_ stream carries items. tuser selects the kind: a load transaction
//   writes one permutation table entry and gives no result; a sample
//   transaction gives voxel indices and yields one result on the m_ stream
//   (noise value in Q2.16 and the solid flag). The table must be loaded
//   before sampling. The cfg_ channel writes the origin, frequency and
//   threshold registers and is always ready; write it only while idle.
//   Throughput is one item per cycle while the receiver does not stall.
//   Without stalls m_tvalid rises once the input transaction has passed
//   fourteen registers, the first loaded at the accepting edge: two front stages
//   for coordinate scaling, one queue slot and eleven back stages set by
//   the chain of three dependent table lookups and the three lerp levels.
//   When the receiver stalls, the back pipeline holds; the eight-entry queue
//   keeps filling and s_tready falls once the queue and front stages together hold eight.
//   Reset empties the pipeline and queue and restores the registers to
//   their reset values; the table contents are undefined until loaded.
`default_nettype none

module perlin_noise_3d_threshold_top
	import pn3t_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // table_index, table_value, vox_x, vox_y, vox_z, pad
	input  wire logic        s_tuser,   // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // noise_value, solid, pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	cfg_t                    cfg_q;
	logic signed [THR_W-1:0] thr_q;
	qstat_t                  qstat;
	item_t                   push_item;
	item_t                   head;
	logic                    push;
	logic                    pop;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x  <= '0;
			cfg_q.origin_y  <= '0;
			cfg_q.origin_z  <= '0;
			cfg_q.frequency <= FREQ_W'(9830);
			thr_q           <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data;
				REG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data;
				REG_ORIGIN_Z:  cfg_q.origin_z  <= cfg_data;
				REG_FREQUENCY: cfg_q.frequency <= cfg_data[FREQ_W-1:0];
				REG_THRESHOLD: thr_q           <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	pn3t_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .cfg(cfg_q), .qstat(qstat),
		.push(push), .push_item(push_item)
	);

	pn3t_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item), .pop(pop),
		.qstat(qstat), .head(head)
	);

	pn3t_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .qstat(qstat), .pop(pop),
		.threshold(thr_q), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule

`default_nettype wire

### sv/pn3t_perm_ram.sv
// One copy of the permutation table: one write port and two registered read ports.
// Depends on pn3t_pkg for the table depth and entry type.
`default_nettype none

module pn3t_perm_ram
	import pn3t_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire logic  we,
	input  wire tidx_t waddr,
	input  wire perm_t wdata,
	input  wire tidx_t raddr0,
	input  wire tidx_t raddr1,
	output perm_t      rdata0,
	output perm_t      rdata1
);

	perm_t mem [TABLE_DEPTH];

	// Write and read move only when the pipeline around the copy advances.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

### sv/pn3t_front.sv
// Front end: accepts stream items and turns voxel indices into cells and fractions.
// Depends on pn3t_pkg; feeds pn3t_queue and throttles itself on the queue fill.
`default_nettype none

module pn3t_front
	import pn3t_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // table_index, table_value, vox_x, vox_y, vox_z, pad
	input  wire logic        s_tuser,   // mode
	input  wire cfg_t        cfg,
	input  wire qstat_t      qstat,
	output logic             push,
	output item_t            push_item
);

	localparam int VLIM_M1 = VOXEL_LIMIT - 1;

	logic                    v_s1;
	logic                    mode_s1;
	tidx_t                   tidx_s1;
	perm_t                   tval_s1;
	logic signed [POS_W-1:0] pos_s1 [3];

	logic                    v_s2;
	item_t                   item_s2;

	logic [VOX_W-1:0]        vox [3];
	logic [VOX_W-1:0]        vsat [3];
	logic signed [POS_W-1:0] org [3];
	logic signed [POS_W-1:0] pos [3];
	logic signed [MUL_W-1:0] prod [3];
	tidx_t                   cidx [3];
	frac_t                   frac [3];
	logic                    acc;
	logic [QCW+1:0]          used;

	// Room is counted over the queue and both stages still on their way to it.
	assign used     = (QCW + 2)'(qstat.count) + (QCW + 2)'(v_s1) + (QCW + 2)'(v_s2);
	assign s_tready = used < (QCW + 2)'(QDEPTH);
	assign acc      = s_tvalid && s_tready;

	// Clamp each index and add the origin in Q.8.
	always_comb begin
		vox[0] = s_tdata[25:16];
		vox[1] = s_tdata[35:26];
		vox[2] = s_tdata[45:36];
		org[0] = POS_W'(cfg.origin_x);
		org[1] = POS_W'(cfg.origin_y);
		org[2] = POS_W'(cfg.origin_z);
		for (int i = 0; i < 3; i++) begin
			vsat[i] = (32'(vox[i]) >= VOXEL_LIMIT) ? VOX_W'(VLIM_M1) : vox[i];
			pos[i]  = org[i] + $signed({{(POS_W - VOX_W - 8){1'b0}}, vsat[i], 8'd0});
		end
	end

	// Scale by the frequency; the cell is taken mod the table size.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = pos_s1[i] * $signed({1'b0, cfg.frequency});
			cidx[i] = prod[i][CELL_LSB +: TABLE_AW];
			frac[i] = prod[i][CELL_LSB-1 -: FRAC_BITS];
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		mode_s1 <= s_tuser;
		tidx_s1 <= s_tdata[7:0];
		tval_s1 <= s_tdata[15:8];
		for (int i = 0; i < 3; i++) begin
			pos_s1[i] <= pos[i];
		end
		item_s2.mode   <= mode_s1;
		item_s2.tindex <= tidx_s1;
		item_s2.tvalue <= tval_s1;
		item_s2.cx     <= cidx[0];
		item_s2.cy     <= cidx[1];
		item_s2.cz     <= cidx[2];
		item_s2.fx     <= frac[0];
		item_s2.fy     <= frac[1];
		item_s2.fz     <= frac[2];
	end

	assign push      = v_s2;
	assign push_item = item_s2;

endmodule

`default_nettype wire

### sv/pn3t_queue.sv
// Short queue that decouples the front end from the noise pipeline.
// Depends on pn3t_pkg for the item type and depth.
`default_nettype none

module pn3t_queue
	import pn3t_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output qstat_t     qstat,
	output item_t      head
);

	item_t          slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	// Pointers and fill count; the front never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	assign head             = slot_q[rd_q];
	assign qstat.head_valid = cnt_q != '0;
	assign qstat.count      = cnt_q;

endmodule

`default_nettype wire

### sv/pn3t_back.sv
// Back end: table hashing, fade curves, gradients, trilinear blend and threshold.
// Depends on pn3t_pkg and pn3t_perm_ram; pulls items from pn3t_queue.
`default_nettype none

module pn3t_back
	import pn3t_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire item_t                   head,
	input  wire qstat_t                  qstat,
	output logic                         pop,
	input  wire logic signed [THR_W-1:0] threshold,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [23:0]                  m_tdata    // noise_value, solid, pad
);

	localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

	// Lerp, first half: weight times difference.
	function automatic prod_t lerp_mul(input fade_t t, input gval_t a, input gval_t b);
		logic signed [GW:0] d;
		d = {b[GW-1], b} - {a[GW-1], a};
		return $signed({1'b0, t}) * d;
	endfunction

	// Lerp, second half: floor shift and add.
	function automatic gval_t lerp_fin(input gval_t a, input prod_t p);
		prod_t sh;
		prod_t s;
		sh = p >>> FRAC_BITS;
		s  = PW'(a) + sh;
		return s[GW-1:0];
	endfunction

	logic adv;
	logic head_load;
	logic o_valid_q;
	logic [NOISE_W-1:0] o_noise_q;
	logic o_solid_q;

	// Stage 1: first table lookup, fade square.
	logic  v_s1, ld_s1;
	tidx_t tidx_s1, cy_s1, cz_s1;
	perm_t tval_s1, pa_s1, pb_s1;
	frac_t f_s1 [3];
	frac_t p_s1 [3];
	// Stage 2: second lookups, fade cube and polynomial.
	logic  v_s2, ld_s2;
	tidx_t tidx_s2, cz_s2;
	perm_t tval_s2, paa_s2, pab_s2, pba_s2, pbb_s2;
	frac_t f_s2 [3];
	frac_t c_s2 [3];
	poly_t q_s2 [3];
	// Stage 3: corner hashes, fade weights.
	logic  sv_s3;
	perm_t h_s3 [8];
	frac_t f_s3 [3];
	fade_t w_s3 [3];
	// Stage 4: gradients.
	logic  sv_s4;
	gval_t g_s4 [8];
	fade_t w_s4 [3];
	// Stages 5 to 10: lerp along x, y and z.
	logic  sv_s5, sv_s6, sv_s7, sv_s8, sv_s9, sv_s10;
	prod_t px_s5 [4];
	gval_t ax_s5 [4];
	fade_t w_s5 [2];
	gval_t lx_s6 [4];
	fade_t w_s6 [2];
	prod_t py_s7 [2];
	gval_t ay_s7 [2];
	fade_t w_s7;
	gval_t ly_s8 [2];
	fade_t w_s8;
	prod_t pz_s9;
	gval_t az_s9;
	gval_t res_s10;

	frac_t                    fh [3];
	logic [2*FRAC_BITS-1:0]   sq [3];
	logic [2*FRAC_BITS-1:0]   cb [3];
	logic [2*FRAC_BITS+3:0]   cq [3];
	logic [QW-1:0]            us [3];
	tidx_t                    a_h, b_h, aa_h, ab_h, ba_h, bb_h;
	gval_t                    xs [3];
	gval_t                    xm [3];
	logic signed [NOISE_W-1:0] noise;

	// The whole pipeline moves whenever the output register is free or taken.
	assign adv       = !o_valid_q || m_tready;
	assign pop       = adv && qstat.head_valid;
	assign head_load = qstat.head_valid && (head.mode == MODE_LOAD);

	// Table copies: each is written by a load at the stage where it is read,
	// so every sample sees exactly the loads that came before it.
	pn3t_perm_ram u_ram0 (
		.clk(clk), .en(adv), .we(head_load), .waddr(head.tindex), .wdata(head.tvalue),
		.raddr0(head.cx), .raddr1(head.cx + TABLE_AW'(1)), .rdata0(pa_s1), .rdata1(pb_s1)
	);

	assign a_h = pa_s1 + cy_s1;
	assign b_h = pb_s1 + cy_s1;

	pn3t_perm_ram u_ram1 (
		.clk(clk), .en(adv), .we(v_s1 && ld_s1), .waddr(tidx_s1), .wdata(tval_s1),
		.raddr0(a_h), .raddr1(a_h + TABLE_AW'(1)), .rdata0(paa_s2), .rdata1(pab_s2)
	);
	pn3t_perm_ram u_ram2 (
		.clk(clk), .en(adv), .we(v_s1 && ld_s1), .waddr(tidx_s1), .wdata(tval_s1),
		.raddr0(b_h), .raddr1(b_h + TABLE_AW'(1)), .rdata0(pba_s2), .rdata1(pbb_s2)
	);

	assign aa_h = paa_s2 + cz_s2;
	assign ab_h = pab_s2 + cz_s2;
	assign ba_h = pba_s2 + cz_s2;
	assign bb_h = pbb_s2 + cz_s2;

	pn3t_perm_ram u_ram3 (
		.clk(clk), .en(adv), .we(v_s2 && ld_s2), .waddr(tidx_s2), .wdata(tval_s2),
		.raddr0(aa_h), .raddr1(aa_h + TABLE_AW'(1)), .rdata0(h_s3[0]), .rdata1(h_s3[4])
	);
	pn3t_perm_ram u_ram4 (
		.clk(clk), .en(adv), .we(v_s2 && ld_s2), .waddr(tidx_s2), .wdata(tval_s2),
		.raddr0(ab_h), .raddr1(ab_h + TABLE_AW'(1)), .rdata0(h_s3[2]), .rdata1(h_s3[6])
	);
	pn3t_perm_ram u_ram5 (
		.clk(clk), .en(adv), .we(v_s2 && ld_s2), .waddr(tidx_s2), .wdata(tval_s2),
		.raddr0(ba_h), .raddr1(ba_h + TABLE_AW'(1)), .rdata0(h_s3[1]), .rdata1(h_s3[5])
	);
	pn3t_perm_ram u_ram6 (
		.clk(clk), .en(adv), .we(v_s2 && ld_s2), .waddr(tidx_s2), .wdata(tval_s2),
		.raddr0(bb_h), .raddr1(bb_h + TABLE_AW'(1)), .rdata0(h_s3[3]), .rdata1(h_s3[7])
	);

	// Fade curve, one multiplication per stage.
	always_comb begin
		fh[0] = head.fx;
		fh[1] = head.fy;
		fh[2] = head.fz;
		for (int i = 0; i < 3; i++) begin
			sq[i] = (2 * FRAC_BITS)'(fh[i]) * (2 * FRAC_BITS)'(fh[i]);
			cb[i] = (2 * FRAC_BITS)'(p_s1[i]) * (2 * FRAC_BITS)'(f_s1[i]);
			cq[i] = (2 * FRAC_BITS + 4)'(c_s2[i]) * (2 * FRAC_BITS + 4)'(q_s2[i]);
			us[i] = cq[i][2*FRAC_BITS+3:FRAC_BITS];
		end
	end

	// Corner offsets along each axis.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xs[i] = $signed({2'b00, f_s3[i]});
			xm[i] = xs[i] - $signed(GW'(ONE_Q));
		end
	end

	// Output format; the threshold is compared where the output register is loaded.
	always_comb begin
		if (FRAC_BITS >= 16) begin
			noise = NOISE_W'(res_s10 >>> SHR);
		end else begin
			noise = NOISE_W'(res_s10) <<< SHL;
		end
	end

	// Control: valid bits of every stage and of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			sv_s3     <= 1'b0;
			sv_s4     <= 1'b0;
			sv_s5     <= 1'b0;
			sv_s6     <= 1'b0;
			sv_s7     <= 1'b0;
			sv_s8     <= 1'b0;
			sv_s9     <= 1'b0;
			sv_s10    <= 1'b0;
			o_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= qstat.head_valid;
			v_s2      <= v_s1;
			sv_s3     <= v_s2 && !ld_s2;
			sv_s4     <= sv_s3;
			sv_s5     <= sv_s4;
			sv_s6     <= sv_s5;
			sv_s7     <= sv_s6;
			sv_s8     <= sv_s7;
			sv_s9     <= sv_s8;
			sv_s10    <= sv_s9;
			o_valid_q <= sv_s10;
		end
	end

	// Payload of every stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			ld_s1   <= head.mode == MODE_LOAD;
			tidx_s1 <= head.tindex;
			tval_s1 <= head.tvalue;
			cy_s1   <= head.cy;
			cz_s1   <= head.cz;
			ld_s2   <= ld_s1;
			tidx_s2 <= tidx_s1;
			tval_s2 <= tval_s1;
			cz_s2   <= cz_s1;
			for (int i = 0; i < 3; i++) begin
				f_s1[i] <= fh[i];
				p_s1[i] <= sq[i][2*FRAC_BITS-1:FRAC_BITS];
				f_s2[i] <= f_s1[i];
				c_s2[i] <= cb[i][2*FRAC_BITS-1:FRAC_BITS];
				q_s2[i] <= (QW'(10) << FRAC_BITS) - QW'(15) * QW'(f_s1[i])
					+ QW'(6) * QW'(p_s1[i]);
				f_s3[i] <= f_s2[i];
				w_s3[i] <= (us[i] > ONE_Q) ? ONE_Q[TW-1:0] : us[i][TW-1:0];
				w_s4[i] <= w_s3[i];
			end
			g_s4[0] <= grad(h_s3[0], xs[0], xs[1], xs[2]);
			g_s4[1] <= grad(h_s3[1], xm[0], xs[1], xs[2]);
			g_s4[2] <= grad(h_s3[2], xs[0], xm[1], xs[2]);
			g_s4[3] <= grad(h_s3[3], xm[0], xm[1], xs[2]);
			g_s4[4] <= grad(h_s3[4], xs[0], xs[1], xm[2]);
			g_s4[5] <= grad(h_s3[5], xm[0], xs[1], xm[2]);
			g_s4[6] <= grad(h_s3[6], xs[0], xm[1], xm[2]);
			g_s4[7] <= grad(h_s3[7], xm[0], xm[1], xm[2]);
			for (int k = 0; k < 4; k++) begin
				px_s5[k] <= lerp_mul(w_s4[0], g_s4[2*k], g_s4[2*k+1]);
				ax_s5[k] <= g_s4[2*k];
				lx_s6[k] <= lerp_fin(ax_s5[k], px_s5[k]);
			end
			w_s5[0] <= w_s4[1];
			w_s5[1] <= w_s4[2];
			w_s6    <= w_s5;
			for (int k = 0; k < 2; k++) begin
				py_s7[k] <= lerp_mul(w_s6[0], lx_s6[2*k], lx_s6[2*k+1]);
				ay_s7[k] <= lx_s6[2*k];
				ly_s8[k] <= lerp_fin(ay_s7[k], py_s7[k]);
			end
			w_s7      <= w_s6[1];
			w_s8      <= w_s7;
			pz_s9     <= lerp_mul(w_s8, ly_s8[0], ly_s8[1]);
			az_s9     <= ly_s8[0];
			res_s10   <= lerp_fin(az_s9, pz_s9);
			o_noise_q <= noise;
			o_solid_q <= noise >= threshold;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {5'd0, o_solid_q, o_noise_q};

endmodule

`default_nettype wire
